// ===== rtl/pairwise_gravity_velocity_update_defines.svh =====
// Assertion macros for the pairwise gravity velocity update block.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef PAIRWISE_GRAVITY_VELOCITY_UPDATE_DEFINES_SVH
`define PAIRWISE_GRAVITY_VELOCITY_UPDATE_DEFINES_SVH
`ifndef SYNTHESIS
// Clocked check, disabled while the active-low reset is asserted
`define PGVU_ASSERT(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("pgvu assertion failed");
// Clocked check without a reset qualifier
`define PGVU_ASSERT_NORST(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("pgvu assertion failed");
`else
`define PGVU_ASSERT(label, clk, rstn, prop)
`define PGVU_ASSERT_NORST(label, clk, prop)
`endif
`endif

// ===== rtl/pgvu_pkg.sv =====
// Shared widths, register codes and sideband types for the gravity kick pipeline.
// No dependencies.
package pgvu_pkg;

    localparam int DATA_W      = 32;
    localparam int DIFF_W      = 33;
    localparam int SQ_W        = 66;
    localparam int ROOT_W      = 34;
    localparam int REM_W       = 38;
    localparam int K_W         = 96;
    localparam int PP_W        = 65;
    localparam int NUM_W       = 129;
    localparam int D_W         = 33;
    localparam int D2_W        = 66;
    localparam int DEN_W       = 99;
    localparam int QBITS       = 40;
    localparam int Q_W         = QBITS + 1;
    localparam int SUM_W       = 43;
    localparam int IN_TDATA_W  = 320;
    localparam int OUT_TDATA_W = 128;
    localparam int OUT_TUSER_W = 2;
    localparam int ADDR_W      = 3;
    localparam int SQRT_LAT    = ROOT_W;
    localparam int DIV_LAT     = QBITS + 1;

    // Register indexes (paddr[2])
    localparam logic REG_GRAVITY   = 1'b0;
    localparam logic REG_TIME_STEP = 1'b1;

    localparam logic [DATA_W-1:0] CFG_RESET = 32'h0001_0000;

    // Sideband needed at the numerator multipliers
    typedef struct packed {
        logic [K_W-1:0]    k1;
        logic [K_W-1:0]    k2;
        logic [DIFF_W-1:0] adx;
        logic [DIFF_W-1:0] ady;
    } early_t;

    // Sideband needed at the final velocity adders
    typedef struct packed {
        logic [DATA_W-1:0] vel1x;
        logic [DATA_W-1:0] vel1y;
        logic [DATA_W-1:0] vel2x;
        logic [DATA_W-1:0] vel2y;
        logic              neg_x;
        logic              neg_y;
        logic              coinc;
    } late_t;

endpackage

// ===== rtl/pgvu_isqrt.sv =====
// Pipelined integer square root, one result bit per stage.
// Depends on pgvu_pkg.
module pgvu_isqrt
    import pgvu_pkg::*;
(
    input  logic              aclk,
    input  logic              en,
    input  logic [SQ_W-1:0]   rad,
    output logic [ROOT_W-1:0] root
);

    localparam int RAD_W = 2 * ROOT_W;

    logic [REM_W-1:0]  rem_reg  [ROOT_W];
    logic [ROOT_W-1:0] root_reg [ROOT_W];
    logic [RAD_W-1:0]  rad_reg  [ROOT_W];

    genvar k;
    generate
        for (k = 0; k < ROOT_W; k++) begin : g_step
            logic [REM_W-1:0]  rem_prev;
            logic [ROOT_W-1:0] root_prev;
            logic [RAD_W-1:0]  rad_prev;
            logic [REM_W-1:0]  rem_sh;
            logic [REM_W-1:0]  trial;
            logic [REM_W-1:0]  rem_next;
            logic [ROOT_W-1:0] root_next;

            if (k == 0) begin : g_first
                assign rem_prev  = '0;
                assign root_prev = '0;
                assign rad_prev  = RAD_W'(rad);
            end else begin : g_rest
                assign rem_prev  = rem_reg[k-1];
                assign root_prev = root_reg[k-1];
                assign rad_prev  = rad_reg[k-1];
            end

            // Bring down the next bit pair and try the next root bit
            always_comb begin
                rem_sh = {rem_prev[REM_W-3:0], rad_prev[RAD_W-1 -: 2]};
                trial  = REM_W'({root_prev, 2'b01});
                if (rem_sh >= trial) begin
                    rem_next  = rem_sh - trial;
                    root_next = {root_prev[ROOT_W-2:0], 1'b1};
                end else begin
                    rem_next  = rem_sh;
                    root_next = {root_prev[ROOT_W-2:0], 1'b0};
                end
            end

            always_ff @(posedge aclk) begin
                if (en) begin
                    rem_reg[k]  <= rem_next;
                    root_reg[k] <= root_next;
                    rad_reg[k]  <= rad_prev << 2;
                end
            end
        end
    endgenerate

    assign root = root_reg[ROOT_W-1];

endmodule

// ===== rtl/pgvu_divcap.sv =====
// Pipelined restoring divider with the quotient held at 2^40.
// One overflow compare stage, then one quotient bit per stage. Depends on pgvu_pkg.
module pgvu_divcap
    import pgvu_pkg::*;
(
    input  logic             aclk,
    input  logic             en,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic [Q_W-1:0]   quot
);

    localparam int CMP_W = DEN_W + QBITS;

    logic [NUM_W-1:0] r_reg   [DIV_LAT];
    logic [DEN_W-1:0] den_reg [DIV_LAT];
    logic [QBITS-1:0] q_reg   [DIV_LAT];
    logic             cap_reg [DIV_LAT];

    // Flag quotients of 2^40 and above
    always_ff @(posedge aclk) begin
        if (en) begin
            r_reg[0]   <= num;
            den_reg[0] <= den;
            q_reg[0]   <= '0;
            cap_reg[0] <= CMP_W'(num) >= {den, {QBITS{1'b0}}};
        end
    end

    genvar k;
    generate
        for (k = 1; k < DIV_LAT; k++) begin : g_step
            logic [CMP_W-1:0] den_sh;
            logic [CMP_W-1:0] r_ext;
            logic [NUM_W-1:0] r_next;
            logic             bit_next;

            // Subtract the shifted divisor where it fits
            always_comb begin
                den_sh = CMP_W'(den_reg[k-1]) << (QBITS - k);
                r_ext  = CMP_W'(r_reg[k-1]);
                if (r_ext >= den_sh) begin
                    r_next   = NUM_W'(r_ext - den_sh);
                    bit_next = 1'b1;
                end else begin
                    r_next   = r_reg[k-1];
                    bit_next = 1'b0;
                end
            end

            always_ff @(posedge aclk) begin
                if (en) begin
                    r_reg[k]   <= r_next;
                    den_reg[k] <= den_reg[k-1];
                    q_reg[k]   <= {q_reg[k-1][QBITS-2:0], bit_next};
                    cap_reg[k] <= cap_reg[k-1];
                end
            end
        end
    endgenerate

    assign quot = cap_reg[DIV_LAT-1] ? {1'b1, {QBITS{1'b0}}}
                                     : {1'b0, q_reg[DIV_LAT-1]};

endmodule

// ===== rtl/pairwise_gravity_velocity_update.sv =====
// Pairwise gravity kick. Throughput one body pair per cycle; the 81-stage
// pipeline (34 square root stages, 41 divider stages) plus the output register
// advances whenever the output register is empty or taken.
// Reset (aresetn low, synchronous) clears all valid bits and sets G and dt to 1.0.
// Depends on pgvu_pkg, pgvu_isqrt, pgvu_divcap and the defines header.
`include "pairwise_gravity_velocity_update_defines.svh"
module pairwise_gravity_velocity_update
    import pgvu_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    // first_pos_x, first_pos_y, first_vel_x, first_vel_y, first_mass,
    // second_pos_x, second_pos_y, second_vel_x, second_vel_y, second_mass
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // first_new_vel_x, first_new_vel_y, second_new_vel_x, second_new_vel_y
    output logic [OUT_TDATA_W-1:0] m_tdata,
    // coincident, saturated
    output logic [OUT_TUSER_W-1:0] m_tuser,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [ADDR_W-1:0]      paddr,
    input  logic [DATA_W-1:0]      pwdata,
    output logic [DATA_W-1:0]      prdata,
    output logic                   pready
);

    localparam int PIPE_N = 3 + SQRT_LAT + 3 + DIV_LAT;

    logic [DATA_W-1:0] grav_reg;
    logic [DATA_W-1:0] ts_reg;
    logic              en;

    logic [PIPE_N-1:0] vld_reg;
    late_t             late_reg [PIPE_N];

    logic [DIFF_W-1:0] adx_a_reg, ady_a_reg;
    logic [63:0]       ga_a_reg, gb_a_reg;
    logic [SQ_W-1:0]   sqx_b_reg, sqy_b_reg;
    logic [63:0]       ka_lo_b_reg, ka_hi_b_reg, kb_lo_b_reg, kb_hi_b_reg;
    logic [DIFF_W-1:0] adx_b_reg, ady_b_reg;
    logic [SQ_W-1:0]   s_c_reg;
    early_t            early_c_reg;
    early_t            early_reg [SQRT_LAT];
    logic [ROOT_W-1:0] root;
    logic [D_W-1:0]    d_e1_reg;
    logic [D2_W-1:0]   d2_e1_reg;
    logic [PP_W-1:0]   np_reg  [4][3];
    logic [SQ_W-1:0]   dp_lo_reg, dp_hi_reg;
    logic [NUM_W-1:0]  num_e2_reg [4];
    logic [NUM_W-1:0]  num_e3_reg [4];
    logic [DEN_W-1:0]  den_e3_reg;
    logic [Q_W-1:0]    quot [4];

    logic                   m_tvalid_reg;
    logic [OUT_TDATA_W-1:0] m_tdata_reg;
    logic [OUT_TUSER_W-1:0] m_tuser_reg;

    // Input field views
    logic [DATA_W-1:0] x1, y1, m1, x2, y2, m2;
    logic [DIFF_W-1:0] dx, dy;
    late_t             late_in;

    assign x1 = s_tdata[31:0];
    assign y1 = s_tdata[63:32];
    assign m1 = s_tdata[159:128];
    assign x2 = s_tdata[191:160];
    assign y2 = s_tdata[223:192];
    assign m2 = s_tdata[319:288];
    assign dx = {x2[DATA_W-1], x2} - {x1[DATA_W-1], x1};
    assign dy = {y2[DATA_W-1], y2} - {y1[DATA_W-1], y1};

    always_comb begin
        late_in.vel1x = s_tdata[95:64];
        late_in.vel1y = s_tdata[127:96];
        late_in.vel2x = s_tdata[255:224];
        late_in.vel2y = s_tdata[287:256];
        late_in.neg_x = dx[DIFF_W-1];
        late_in.neg_y = dy[DIFF_W-1];
        late_in.coinc = (dx == '0) && (dy == '0);
    end

    // Configuration registers
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_TIME_STEP) ? ts_reg : grav_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grav_reg <= CFG_RESET;
            ts_reg   <= CFG_RESET;
        end else if (psel && penable && pwrite && pready) begin
            case (paddr[2])
                REG_GRAVITY:   grav_reg <= pwdata;
                REG_TIME_STEP: ts_reg   <= pwdata;
                default: ;
            endcase
        end
    end

    // Whole pipeline advances when the output register can take a beat
    assign en       = !m_tvalid_reg || m_tready;
    assign s_tready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[PIPE_N-2:0], s_tvalid};
        end
    end

    // Carry velocities and signs down to the adders
    always_ff @(posedge aclk) begin
        if (en) begin
            late_reg[0] <= late_in;
            for (int i = 1; i < PIPE_N; i++) begin
                late_reg[i] <= late_reg[i-1];
            end
        end
    end

    // Stage A: magnitudes of the offsets, G times each mass
    always_ff @(posedge aclk) begin
        if (en) begin
            adx_a_reg <= dx[DIFF_W-1] ? DIFF_W'(~dx + 1'b1) : dx;
            ady_a_reg <= dy[DIFF_W-1] ? DIFF_W'(~dy + 1'b1) : dy;
            ga_a_reg  <= 64'(grav_reg * m2);
            gb_a_reg  <= 64'(grav_reg * m1);
        end
    end

    // Stage B: squares, partial products of the dt scaling
    always_ff @(posedge aclk) begin
        if (en) begin
            sqx_b_reg   <= SQ_W'(adx_a_reg * adx_a_reg);
            sqy_b_reg   <= SQ_W'(ady_a_reg * ady_a_reg);
            ka_lo_b_reg <= 64'(ga_a_reg[31:0] * ts_reg);
            ka_hi_b_reg <= 64'(ga_a_reg[63:32] * ts_reg);
            kb_lo_b_reg <= 64'(gb_a_reg[31:0] * ts_reg);
            kb_hi_b_reg <= 64'(gb_a_reg[63:32] * ts_reg);
            adx_b_reg   <= adx_a_reg;
            ady_b_reg   <= ady_a_reg;
        end
    end

    // Stage C: squared distance and the two force scales
    always_ff @(posedge aclk) begin
        if (en) begin
            s_c_reg         <= sqx_b_reg + sqy_b_reg;
            early_c_reg.k1  <= K_W'(ka_lo_b_reg) + {ka_hi_b_reg, 32'b0};
            early_c_reg.k2  <= K_W'(kb_lo_b_reg) + {kb_hi_b_reg, 32'b0};
            early_c_reg.adx <= adx_b_reg;
            early_c_reg.ady <= ady_b_reg;
        end
    end

    pgvu_isqrt u_isqrt (
        .aclk (aclk),
        .en   (en),
        .rad  (s_c_reg),
        .root (root)
    );

    // Hold the scales beside the square root
    always_ff @(posedge aclk) begin
        if (en) begin
            early_reg[0] <= early_c_reg;
            for (int i = 1; i < SQRT_LAT; i++) begin
                early_reg[i] <= early_reg[i-1];
            end
        end
    end

    // Stage E1: d squared, numerator partial products
    always_ff @(posedge aclk) begin
        if (en) begin
            d_e1_reg  <= root[D_W-1:0];
            d2_e1_reg <= D2_W'(root * root);
            for (int j = 0; j < 3; j++) begin
                np_reg[0][j] <= PP_W'(early_reg[SQRT_LAT-1].k1[32*j +: 32]
                                      * early_reg[SQRT_LAT-1].adx);
                np_reg[1][j] <= PP_W'(early_reg[SQRT_LAT-1].k1[32*j +: 32]
                                      * early_reg[SQRT_LAT-1].ady);
                np_reg[2][j] <= PP_W'(early_reg[SQRT_LAT-1].k2[32*j +: 32]
                                      * early_reg[SQRT_LAT-1].adx);
                np_reg[3][j] <= PP_W'(early_reg[SQRT_LAT-1].k2[32*j +: 32]
                                      * early_reg[SQRT_LAT-1].ady);
            end
        end
    end

    // Stage E2: d cubed partial products, numerator sums
    always_ff @(posedge aclk) begin
        if (en) begin
            dp_lo_reg <= SQ_W'(d2_e1_reg[32:0] * d_e1_reg);
            dp_hi_reg <= SQ_W'(d2_e1_reg[65:33] * d_e1_reg);
            for (int c = 0; c < 4; c++) begin
                num_e2_reg[c] <= NUM_W'(np_reg[c][0])
                               + (NUM_W'(np_reg[c][1]) << 32)
                               + (NUM_W'(np_reg[c][2]) << 64);
            end
        end
    end

    // Stage E3: d cubed
    always_ff @(posedge aclk) begin
        if (en) begin
            den_e3_reg <= DEN_W'(dp_lo_reg) + (DEN_W'(dp_hi_reg) << 33);
            for (int c = 0; c < 4; c++) begin
                num_e3_reg[c] <= num_e2_reg[c];
            end
        end
    end

    // Quotients: first body x, y then second body x, y
    genvar g;
    generate
        for (g = 0; g < 4; g++) begin : g_div
            pgvu_divcap u_divcap (
                .aclk (aclk),
                .en   (en),
                .num  (num_e3_reg[g]),
                .den  (den_e3_reg),
                .quot (quot[g])
            );
        end
    endgenerate

    // Add a signed kick to a velocity and clamp; top bit flags a clamp
    function automatic logic [DATA_W:0] apply_kick(
        input logic [DATA_W-1:0] v,
        input logic [Q_W-1:0]    q,
        input logic              neg
    );
        logic signed [SUM_W-1:0] vmax;
        logic signed [SUM_W-1:0] vs;
        logic signed [SUM_W-1:0] qs;
        logic signed [SUM_W-1:0] sum;
        vmax = SUM_W'(32'h7FFF_FFFF);
        vs   = SUM_W'($signed(v));
        qs   = $signed(SUM_W'(q));
        if (neg) begin
            qs = -qs;
        end
        sum = vs + qs;
        if (sum > vmax) begin
            return {1'b1, 32'h7FFF_FFFF};
        end else if (sum < ~vmax) begin
            return {1'b1, 32'h8000_0000};
        end
        return {1'b0, sum[DATA_W-1:0]};
    endfunction

    late_t             late_o;
    logic [DATA_W:0]   k1x, k1y, k2x, k2y;

    assign late_o = late_reg[PIPE_N-1];
    assign k1x = apply_kick(late_o.vel1x, quot[0], late_o.neg_x);
    assign k1y = apply_kick(late_o.vel1y, quot[1], late_o.neg_y);
    assign k2x = apply_kick(late_o.vel2x, quot[2], !late_o.neg_x);
    assign k2y = apply_kick(late_o.vel2y, quot[3], !late_o.neg_y);

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (en) begin
            m_tvalid_reg <= vld_reg[PIPE_N-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            if (late_o.coinc) begin
                m_tdata_reg <= {late_o.vel2y, late_o.vel2x, late_o.vel1y, late_o.vel1x};
                m_tuser_reg <= 2'b01;
            end else begin
                m_tdata_reg <= {k2y[DATA_W-1:0], k2x[DATA_W-1:0],
                                k1y[DATA_W-1:0], k1x[DATA_W-1:0]};
                m_tuser_reg <= {k1x[DATA_W] | k1y[DATA_W] | k2x[DATA_W] | k2y[DATA_W],
                                1'b0};
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    `PGVU_ASSERT(a_coinc_no_sat, aclk, aresetn, m_tvalid_reg && m_tuser_reg[0] |-> !m_tuser_reg[1])
    `PGVU_ASSERT(a_stall_holds_pipe, aclk, aresetn, !en |=> $stable(vld_reg))
    `PGVU_ASSERT(a_tail_reaches_out, aclk, aresetn, en && vld_reg[PIPE_N-1] |=> m_tvalid_reg)

endmodule

// ===== dv/pairwise_gravity_velocity_update_tb.sv =====
// Self-checking testbench for the pairwise gravity velocity update block.
// Depends on pgvu_pkg and the block RTL; drives body pairs and APB writes.
module pairwise_gravity_velocity_update_tb;
    import pgvu_pkg::*;

    typedef struct {
        logic [31:0] x1, y1, vx1, vy1, m1;
        logic [31:0] x2, y2, vx2, vy2, m2;
    } body_pair_t;

    typedef struct {
        logic [31:0] v1x, v1y, v2x, v2y;
        logic        coinc, sat;
    } new_vel_t;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic [IN_TDATA_W-1:0]  s_tdata = '0;    // x1,y1,vx1,vy1,m1,x2,y2,vx2,vy2,m2
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;         // v1x,v1y,v2x,v2y
    logic [OUT_TUSER_W-1:0] m_tuser;         // coincident, saturated
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic                   psel = 1'b0;
    logic                   penable = 1'b0;
    logic                   pwrite = 1'b0;
    logic [ADDR_W-1:0]      paddr = '0;
    logic [DATA_W-1:0]      pwdata = '0;
    logic [DATA_W-1:0]      prdata;
    logic                   pready;

    body_pair_t  pair_queue[$];
    new_vel_t    vel_queue[$];
    body_pair_t  shown_pair;
    logic [31:0] grav_k = CFG_RESET;
    logic [31:0] step_k = CFG_RESET;
    int unsigned send_idle = 0;
    int unsigned recv_idle = 0;
    int unsigned errors = 0;
    int unsigned beats_in = 0;
    int unsigned beats_out = 0;
    int unsigned coinc_seen = 0;
    int unsigned sat_seen = 0;
    int unsigned quiet_cycles = 0;

    pairwise_gravity_velocity_update i_dut (.*);

    always #1 aclk = ~aclk;

    // Capped magnitude of G*m*dt*|c| / d^3
    function automatic longint kick_size(logic [31:0] g, logic [31:0] dt, logic [31:0] m,
                                         logic [32:0] c, logic [159:0] den);
        logic [159:0] num, quo;
        num = 160'(g) * 160'(m) * 160'(dt) * 160'(c);
        quo = num / den;
        if (quo >= (160'(1) << 40)) quo = 160'(1) << 40;
        return longint'(quo[40:0]);
    endfunction

    // Add a kick to a velocity and clamp to signed 32 bits
    function automatic logic [31:0] clamp_add(logic [31:0] v, longint dv, ref logic sat);
        longint s;
        s = longint'($signed(v)) + dv;
        if (s > 64'sd2147483647) begin
            s = 64'sd2147483647;
            sat = 1'b1;
        end
        if (s < -64'sd2147483648) begin
            s = -64'sd2147483648;
            sat = 1'b1;
        end
        return s[31:0];
    endfunction

    function automatic new_vel_t predict_kick(body_pair_t p, logic [31:0] g, logic [31:0] dt);
        new_vel_t     r;
        logic [33:0]  dx, dy, cand;
        logic [32:0]  adx, ady;
        logic [33:0]  d;
        logic [159:0] sq, den;
        longint       q1x, q1y, q2x, q2y;
        logic         sat;
        dx = {{2{p.x2[31]}}, p.x2} - {{2{p.x1[31]}}, p.x1};
        dy = {{2{p.y2[31]}}, p.y2} - {{2{p.y1[31]}}, p.y1};
        adx = dx[33] ? 33'(-dx) : dx[32:0];
        ady = dy[33] ? 33'(-dy) : dy[32:0];
        if (adx == 0 && ady == 0) begin
            r = '{p.vx1, p.vy1, p.vx2, p.vy2, 1'b1, 1'b0};
            return r;
        end
        sq = 160'(adx) * 160'(adx) + 160'(ady) * 160'(ady);
        // integer square root, one bit at a time
        d = '0;
        for (int b = 33; b >= 0; b--) begin
            cand = d | (34'd1 << b);
            if (160'(cand) * 160'(cand) <= sq) d = cand;
        end
        den = 160'(d) * 160'(d) * 160'(d);
        q1x = kick_size(g, dt, p.m2, adx, den);
        q1y = kick_size(g, dt, p.m2, ady, den);
        q2x = kick_size(g, dt, p.m1, adx, den);
        q2y = kick_size(g, dt, p.m1, ady, den);
        if (dx[33]) begin
            q1x = -q1x;
            q2x = -q2x;
        end
        if (dy[33]) begin
            q1y = -q1y;
            q2y = -q2y;
        end
        sat = 1'b0;
        r.v1x = clamp_add(p.vx1, q1x, sat);
        r.v1y = clamp_add(p.vy1, q1y, sat);
        r.v2x = clamp_add(p.vx2, -q2x, sat);
        r.v2y = clamp_add(p.vy2, -q2y, sat);
        r.coinc = 1'b0;
        r.sat = sat;
        return r;
    endfunction

    // Driver: present pairs, predict on each accepted beat
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                vel_queue.push_back(predict_kick(shown_pair, grav_k, step_k));
                void'(pair_queue.pop_front());
                beats_in++;
            end
            if (!s_tvalid || s_tready) begin
                if (pair_queue.size() > 0 && $urandom_range(99) >= send_idle) begin
                    shown_pair <= pair_queue[0];
                    s_tdata <= {pair_queue[0].m2, pair_queue[0].vy2, pair_queue[0].vx2,
                                pair_queue[0].y2, pair_queue[0].x2, pair_queue[0].m1,
                                pair_queue[0].vy1, pair_queue[0].vx1, pair_queue[0].y1,
                                pair_queue[0].x1};
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: compare each result beat with the oldest prediction
    always @(posedge aclk) begin
        new_vel_t want;
        if (aresetn && m_tvalid && m_tready) begin
            beats_out++;
            if (vel_queue.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result beat %h/%b", m_tdata, m_tuser);
            end else begin
                want = vel_queue.pop_front();
                coinc_seen += want.coinc;
                sat_seen += want.sat;
                if (m_tdata !== {want.v2y, want.v2x, want.v1y, want.v1x}
                    || m_tuser !== {want.sat, want.coinc}) begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch beat %0d: exp %h %h %h %h c%b s%b got %h c%b s%b",
                                 beats_out, want.v1x, want.v1y, want.v2x, want.v2y,
                                 want.coinc, want.sat, m_tdata, m_tuser[0], m_tuser[1]);
                end
            end
        end
        m_tready <= ($urandom_range(99) >= recv_idle);
    end

    // Watchdog: end the run when nothing moves for too long
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > 20000) begin
            $display("timeout: no beat for %0d cycles", quiet_cycles);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic reg_write(input logic idx, input logic [31:0] val);
        @(posedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ADDR_W'(idx) << 2;
        pwdata <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (idx == REG_GRAVITY) grav_k = val;
        else step_k = val;
    endtask

    // Hold until the pipe is drained, then let it settle
    task automatic drain();
        while (pair_queue.size() > 0 || vel_queue.size() > 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
    endtask

    function automatic logic [31:0] pick_word();
        case ($urandom_range(5))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'h0;
            3: return $urandom >> $urandom_range(31);
            default: return $urandom;
        endcase
    endfunction

    // Mostly nearby pairs with modest masses; some coincident pairs, some fully random noise
    function automatic body_pair_t random_pair();
        body_pair_t p;
        int unsigned span;
        p.x1 = $urandom;
        p.y1 = $urandom;
        p.vx1 = $urandom >> $urandom_range(31);
        p.vy1 = $urandom;
        p.vx2 = $urandom >> $urandom_range(31);
        p.vy2 = $urandom;
        p.m1 = $urandom >> $urandom_range(31);
        p.m2 = $urandom >> $urandom_range(31);
        case ($urandom_range(9))
            0: begin
                p.x2 = pick_word();
                p.y2 = pick_word();
                p.m1 = pick_word();
                p.m2 = pick_word();
            end
            1: begin
                p.x2 = p.x1;
                p.y2 = p.y1;
            end
            default: begin
                span = $urandom_range(28, 1);
                p.x2 = p.x1 + (($urandom >> (32 - span)) - (1 << (span - 1)));
                p.y2 = p.y1 + (($urandom >> (32 - span)) - (1 << (span - 1)));
            end
        endcase
        return p;
    endfunction

    initial begin
        body_pair_t p;
        logic [31:0] g_set[8];
        logic [31:0] t_set[8];
        g_set = '{32'h0001_0000, 32'h0, 32'hffff_ffff, 32'hffff_ffff,
                  32'h0000_0001, 32'h0010_0000, 32'h0000_4000, 32'h0001_0000};
        t_set = '{32'h0001_0000, 32'hffff_ffff, 32'hffff_ffff, 32'h0,
                  32'h0000_0001, 32'h0000_1000, 32'h0040_0000, 32'h0001_0000};
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(posedge aclk);

        for (int ph = 0; ph < 8; ph++) begin
            if (ph == 7) begin
                g_set[ph] = $urandom;
                t_set[ph] = $urandom >> $urandom_range(31);
            end
            reg_write(REG_GRAVITY, g_set[ph]);
            reg_write(REG_TIME_STEP, t_set[ph]);
            case (ph % 4)
                0: begin send_idle = 0;  recv_idle = 0;  end
                1: begin send_idle = 76; recv_idle = 0;  end
                2: begin send_idle = 0;  recv_idle = 76; end
                default: begin send_idle = 35; recv_idle = 35; end
            endcase
            if (ph == 0) begin
                // coincident bodies, with extreme velocities
                pair_queue.push_back('{32'h1234_5678, 32'h8000_0000, 32'h7fff_ffff,
                    32'h8000_0000, 32'hffff_ffff, 32'h1234_5678, 32'h8000_0000,
                    32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff});
                // widest separation
                pair_queue.push_back('{32'h8000_0000, 32'h8000_0000, 0, 0, 32'hffff_ffff,
                    32'h7fff_ffff, 32'h7fff_ffff, 0, 0, 32'hffff_ffff});
                pair_queue.push_back('{32'h7fff_ffff, 32'h0, 0, 0, 32'hffff_ffff,
                    32'h8000_0000, 32'h0, 0, 0, 32'hffff_ffff});
                // unit offsets on both axes with huge masses: saturate both ways
                pair_queue.push_back('{32'h0, 32'h0, 32'h7fff_ff00, 32'h8000_0100,
                    32'hffff_ffff, 32'h1, 32'h1, 32'h8000_0100, 32'h7fff_ff00, 32'hffff_ffff});
                pair_queue.push_back('{32'h1, 32'h1, 32'h8000_0000, 32'h7fff_ffff,
                    32'hffff_ffff, 32'h0, 32'h0, 32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff});
                // zero masses
                pair_queue.push_back('{32'h0001_0000, 32'h0, 32'h5, 32'h6, 32'h0,
                    32'h0, 32'h0002_0000, 32'h7, 32'h8, 32'h0});
                // ordinary masses: one-unit spacing along x, three units along y, then a diagonal pair
                pair_queue.push_back('{32'h0, 32'h0, 0, 0, 32'h0001_0000,
                    32'h0001_0000, 32'h0, 0, 0, 32'h0002_0000});
                pair_queue.push_back('{32'h0, 32'h0003_0000, 0, 0, 32'h0001_0000,
                    32'h0, 32'h0, 0, 0, 32'h0001_0000});
                pair_queue.push_back('{32'hfff0_0000, 32'h0010_0000, 32'h1000, 32'hffff_f000,
                    32'h0100_0000, 32'h0010_0000, 32'hfff0_0000, 32'hffff_0000, 32'h0001_0000,
                    32'h0000_8000});
                for (int i = 0; i < 8; i++) begin
                    p = '{pick_word(), pick_word(), pick_word(), pick_word(), pick_word(),
                          pick_word(), pick_word(), pick_word(), pick_word(), pick_word()};
                    pair_queue.push_back(p);
                end
            end
            for (int i = 0; i < 225; i++) pair_queue.push_back(random_pair());
            drain();
        end

        $display("covered %0d pairs over 8 G/dt settings, %0d coincident, %0d saturated",
                 beats_in, coinc_seen, sat_seen);
        $display("%0d result beats checked, %0d mismatches", beats_out, errors);
        if (errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/pgvu_pkg.sv
rtl/pgvu_isqrt.sv
rtl/pgvu_divcap.sv
rtl/pairwise_gravity_velocity_update.sv
dv/pairwise_gravity_velocity_update_tb.sv
